FILE: hdl/lee_pkg.sv
// Shared types and constants of the line editor with erase and kill codes.
package lee_pkg;

   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] RESET_ERASE  = 8'd35;
   localparam logic [CHAR_W-1:0] RESET_KILL   = 8'd64;

   // Register indexes on the configuration port.
   typedef enum logic [0:0] {
      CSR_ERASE = 1'b0,
      CSR_KILL  = 1'b1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;        // append the input character to the line
      logic pop;         // remove the newest character
      logic clear;       // empty the line
      logic start;       // rewind the read pointer for a readout
      logic load_char;   // load the stored character at the read pointer into the output
      logic load_nl;     // load a newline into the output
      logic last;        // mark the loaded beat as the last of the line
   } lee_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_nl;       // input character is a newline
      logic is_erase;    // input character is the erase code
      logic is_kill;     // input character is the kill code
      logic empty;       // line holds no characters
      logic full;        // line store is full
      logic at_end;      // read pointer has passed the last stored character
      logic at_final;    // read pointer sits on the last stored character
      logic out_free;    // output register can take a beat this cycle
   } lee_sts_type;

endpackage

FILE: hdl/lee_dpath.sv
// Datapath of the line editor: line store, fill count, read pointer, output register.
module lee_dpath #(
   parameter int LINE_DEPTH = 63
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lee_pkg::CHAR_W-1:0]  char_in,
   input  logic                        csr_write,
   input  lee_pkg::csr_index_type      csr_index,
   input  logic [lee_pkg::CHAR_W-1:0]  csr_data,
   input  lee_pkg::lee_cmd_type        cmd,
   output lee_pkg::lee_sts_type        sts,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [lee_pkg::CHAR_W-1:0]  char_out,
   output logic                        last
);

   localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [lee_pkg::CHAR_W-1:0] line_mem [LINE_DEPTH];

   logic [CNT_W-1:0]           fill_ff,  fill_in;
   logic [CNT_W-1:0]           rptr_ff,  rptr_in;
   logic [lee_pkg::CHAR_W-1:0] erase_ff, erase_in;
   logic [lee_pkg::CHAR_W-1:0] kill_ff,  kill_in;
   logic                       valid_ff, valid_in;
   logic                       last_ff;
   logic                       sel_nl_ff;
   logic [lee_pkg::CHAR_W-1:0] rdata_ff;

   always_comb begin
      sts.is_nl    = (char_in == lee_pkg::NEWLINE_CODE);
      sts.is_erase = (char_in == erase_ff);
      sts.is_kill  = (char_in == kill_ff);
      sts.empty    = (fill_ff == '0);
      sts.full     = (fill_ff == CNT_W'(LINE_DEPTH));
      sts.at_end   = (rptr_ff == fill_ff);
      sts.at_final = ((rptr_ff + CNT_W'(1)) == fill_ff);
      sts.out_free = !valid_ff || out_ready;
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.push) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - CNT_W'(1);
      end

      rptr_in = rptr_ff;
      if (cmd.start) begin
         rptr_in = '0;
      end else if (cmd.load_char) begin
         rptr_in = rptr_ff + CNT_W'(1);
      end

      erase_in = erase_ff;
      kill_in  = kill_ff;
      if (csr_write) begin
         unique case (csr_index)
            lee_pkg::CSR_ERASE: erase_in = csr_data;
            lee_pkg::CSR_KILL:  kill_in  = csr_data;
            default: ;
         endcase
      end

      if (cmd.load_char || cmd.load_nl) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rptr_ff  <= '0;
         erase_ff <= lee_pkg::RESET_ERASE;
         kill_ff  <= lee_pkg::RESET_KILL;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         rptr_ff  <= rptr_in;
         erase_ff <= erase_in;
         kill_ff  <= kill_in;
         valid_ff <= valid_in;
      end
   end

   // Line store: one write port at the fill count, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         line_mem[fill_ff[ADDR_W-1:0]] <= char_in;
      end
      if (cmd.load_char) begin
         rdata_ff <= line_mem[rptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char || cmd.load_nl) begin
         sel_nl_ff <= cmd.load_nl;
         last_ff   <= cmd.last;
      end
   end

   assign out_valid = valid_ff;
   assign char_out  = sel_nl_ff ? lee_pkg::NEWLINE_CODE : rdata_ff;
   assign last      = last_ff;

endmodule

FILE: hdl/lee_ctrl.sv
// Controller of the line editor: decodes input beats and sequences the line readout.
module lee_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  end_of_input,
   input  lee_pkg::lee_sts_type  sts,
   output lee_pkg::lee_cmd_type  cmd
);

   typedef enum logic [0:0] {
      ST_EDIT,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      with_nl_ff, with_nl_in;
   logic      accept;

   assign in_ready = (state_ff == ST_EDIT);
   assign accept   = in_valid && in_ready;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      with_nl_in = with_nl_ff;
      unique case (state_ff)
         ST_EDIT: begin
            if (accept) begin
               priority if (end_of_input) begin
                  if (!sts.empty) begin
                     cmd.start  = 1'b1;
                     with_nl_in = 1'b0;
                     state_in   = ST_DRAIN;
                  end
               end else if (sts.is_nl) begin
                  cmd.start  = 1'b1;
                  with_nl_in = 1'b1;
                  state_in   = ST_DRAIN;
               end else if (sts.is_erase) begin
                  cmd.pop = !sts.empty;
               end else if (sts.is_kill) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.push = !sts.full;
               end
            end
         end
         ST_DRAIN: begin
            if (sts.out_free) begin
               if (!sts.at_end) begin
                  cmd.load_char = 1'b1;
                  cmd.last      = !with_nl_ff && sts.at_final;
               end else begin
                  cmd.load_nl = 1'b1;
                  cmd.last    = 1'b1;
               end
               if (cmd.last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_EDIT;
               end
            end
         end
         default: state_in = ST_EDIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_EDIT;
         with_nl_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         with_nl_ff <= with_nl_in;
      end
   end

endmodule

FILE: hdl/line_editor_erase_kill.sv
// Top level of the line editor with erase and kill codes.
//
//   Channel | Ports                            | Beat carries
//   --------+----------------------------------+--------------------------------------
//   input   | req_tvalid/req_tready/req_tdata  | one character, end-of-input in tuser
//   result  | rsp_tvalid/rsp_tready/rsp_tdata  | one character of the line, tlast marks
//           |                                  | the final beat of the line
//   config  | csr_valid/csr_ready/csr_index    | erase code (index 0) or kill code
//           |                                  | (index 1) in csr_data
//
// An ordinary character, an erase or a kill is taken in the edit state, so such beats
// stream at one per cycle. A newline, or an end-of-input beat while the line is not
// empty, starts a readout of the stored line: one result beat per cycle while
// rsp_tready is high, set by the single read port of the line store. A newline
// readout ends with an extra newline beat after the stored characters.
// A stall on the result side holds the readout where it is; the input stays
// closed until the last beat of the line has been loaded into the output register.
// The synchronous reset empties the line and restores the default erase and kill
// codes; the line store itself needs no clearing, since only filled entries are read.
// The configuration port is always ready.
module line_editor_erase_kill #(
   parameter int LINE_DEPTH = 63
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] char_in
   input  logic                         req_tuser,   // [0] end_of_input

   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [7:0] char_out
   output logic                         rsp_tlast,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [0:0]                   csr_index,
   input  logic [7:0]                   csr_data
);

   lee_pkg::lee_cmd_type cmd;
   lee_pkg::lee_sts_type sts;
   logic                 csr_write;

   // Register writes land at once; the port never pushes back.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   lee_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .end_of_input (req_tuser),
      .sts          (sts),
      .cmd          (cmd)
   );

   lee_dpath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .char_in   (req_tdata),
      .csr_write (csr_write),
      .csr_index (lee_pkg::csr_index_type'(csr_index)),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .char_out  (rsp_tdata),
      .last      (rsp_tlast)
   );

endmodule
